FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the lowest-common-ancestor unit.
// Define ASSERT_OFF to compile all checks away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// ante in this cycle implies cons in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// ante in this cycle implies cons in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/core/blca_pkg.sv
// Shared types and constants of the binary lifting LCA unit.
// Used by blca_store and binary_lifting_lca_unit; depends on nothing.
package blca_pkg;

	localparam int NODE_W     = 10;
	localparam int MAX_NODES  = 1 << NODE_W;
	localparam int LOG_LEVELS = 10;
	localparam int LVL_W      = $clog2(LOG_LEVELS);
	localparam int TBL_DEPTH  = MAX_NODES * LOG_LEVELS;
	localparam int TBL_AW     = $clog2(TBL_DEPTH);
	localparam int CMD_W      = 2;
	localparam int S_TDATA_W  = 32;
	localparam int M_TDATA_W  = 16;

	typedef logic [NODE_W-1:0] node_t;
	typedef logic [LVL_W-1:0]  lvl_t;

	// command codes carried in s_tuser
	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD  = 2'd0,
		CMD_BUILD = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// result kinds carried in m_tuser
	localparam logic KIND_ACK    = 1'b0;
	localparam logic KIND_ANSWER = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_B_RD0,
		ST_B_RD1,
		ST_B_WR,
		ST_Q_DV,
		ST_Q_SWAP,
		ST_L_CHK,
		ST_L_TBL,
		ST_L_DEP,
		ST_L_END,
		ST_J_RV,
		ST_J_CMP,
		ST_F_CAP,
		ST_RESP
	} state_t;

	// ancestor table access: one read and one write per cycle
	typedef struct packed {
		logic  rd_en;
		lvl_t  rd_lvl;
		node_t rd_node;
		logic  wr_en;
		lvl_t  wr_lvl;
		node_t wr_node;
		node_t wr_data;
	} tbl_req_t;

	// depth store access: one read and one write per cycle
	typedef struct packed {
		logic  rd_en;
		node_t rd_node;
		logic  wr_en;
		node_t wr_node;
		node_t wr_data;
	} dep_req_t;

endpackage

FILE: rtl/core/binary_lifting_lca_unit.sv
// Lowest common ancestor by binary lifting. One item is worked at a time; each gives
// one result beat. Build: two table reads and one write per node per level over levels
// 1..9, set by the serial reads of the ancestor table. Query: two depth reads, one check
// per level while lifting (plus a table and a depth read per jump), two table reads per
// level while jumping both nodes, one final parent read; the single table read port sets
// this order. When the lifted node already equals the other one the joint jump is
// skipped.
// Depends on blca_pkg, blca_store and assert_macros.svh.
`include "assert_macros.svh"

module binary_lifting_lca_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: node_count
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [9:0] first_node, [19:10] second_node, [29:20] node_depth
	input  logic [1:0]  s_tuser,   // [1:0] cmd
	// result beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [9:0] ancestor
	output logic        m_tuser    // [0] result_kind
);
	import blca_pkg::*;

	localparam lvl_t TOP_LVL = lvl_t'(LOG_LEVELS - 1);
	localparam lvl_t LVL_ONE = lvl_t'(1);

	state_t   state_q, state_d;
	node_t    u_q, u_d, v_q, v_d;
	node_t    du_q, du_d, dv_q, dv_d;
	node_t    pu_q, pu_d;
	node_t    idx_q, idx_d;
	lvl_t     lvl_q, lvl_d;
	node_t    ans_q, ans_d;
	logic     kind_q, kind_d;
	node_t    node_count_q;
	logic     m_valid_q;
	node_t    m_anc_q;
	logic     m_kind_q;

	tbl_req_t tbl_req;
	dep_req_t dep_req;
	node_t    tbl_rdata;
	node_t    dep_rdata;

	logic         in_acc;
	cmd_t         in_cmd;
	node_t        in_a, in_b, in_d;
	logic [NODE_W:0] diff;
	logic [NODE_W:0] step;
	logic         lift_jump;
	node_t        nu, nv;
	logic         out_free;

	blca_store u_store (
		.clk       (clk),
		.tbl_req   (tbl_req),
		.dep_req   (dep_req),
		.tbl_rdata (tbl_rdata),
		.dep_rdata (dep_rdata)
	);

	// input unpacking
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_cmd   = cmd_t'(s_tuser);
	assign in_a     = s_tdata[NODE_W-1:0];
	assign in_b     = s_tdata[2*NODE_W-1:NODE_W];
	assign in_d     = s_tdata[3*NODE_W-1:2*NODE_W];

	// lift test: depth(u) - depth(v) >= 2^lvl, signed
	assign diff      = {1'b0, du_q} - {1'b0, dv_q};
	assign step      = (NODE_W+1)'(1) << lvl_q;
	assign lift_jump = !diff[NODE_W] && (diff >= step);

	// joint jump: move both while the ancestors differ
	assign nu = (pu_q != tbl_rdata) ? pu_q : u_q;
	assign nv = (pu_q != tbl_rdata) ? tbl_rdata : v_q;

	assign out_free = !m_valid_q || m_tready;

	// sequencer: next state, memory requests, work registers
	always_comb begin
		state_d = state_q;
		u_d     = u_q;
		v_d     = v_q;
		du_d    = du_q;
		dv_d    = dv_q;
		pu_d    = pu_q;
		idx_d   = idx_q;
		lvl_d   = lvl_q;
		ans_d   = ans_q;
		kind_d  = kind_q;
		tbl_req = '0;
		dep_req = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					ans_d  = '0;
					kind_d = KIND_ACK;
					case (in_cmd)
						CMD_LOAD: begin
							tbl_req.wr_en   = (in_a != '0);
							tbl_req.wr_lvl  = '0;
							tbl_req.wr_node = in_a;
							tbl_req.wr_data = in_b;
							dep_req.wr_en   = (in_a != '0);
							dep_req.wr_node = in_a;
							dep_req.wr_data = in_d;
							state_d = ST_RESP;
						end
						CMD_BUILD: begin
							lvl_d   = LVL_ONE;
							idx_d   = node_t'(1);
							state_d = (node_count_q == '0) ? ST_RESP : ST_B_RD0;
						end
						CMD_QUERY: begin
							kind_d = KIND_ANSWER;
							u_d    = in_a;
							v_d    = in_b;
							dep_req.rd_en   = 1'b1;
							dep_req.rd_node = in_a;
							state_d = ST_Q_DV;
						end
						default: state_d = ST_RESP;
					endcase
				end
			end
			// build: table[lvl][idx] = table[lvl-1][table[lvl-1][idx]]
			ST_B_RD0: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_lvl  = lvl_q - LVL_ONE;
				tbl_req.rd_node = idx_q;
				state_d = ST_B_RD1;
			end
			ST_B_RD1: begin
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_lvl  = lvl_q - LVL_ONE;
				tbl_req.rd_node = tbl_rdata;
				state_d = ST_B_WR;
			end
			ST_B_WR: begin
				tbl_req.wr_en   = 1'b1;
				tbl_req.wr_lvl  = lvl_q;
				tbl_req.wr_node = idx_q;
				tbl_req.wr_data = tbl_rdata;
				state_d = ST_B_RD0;
				if (idx_q == node_count_q) begin
					idx_d = node_t'(1);
					if (lvl_q == TOP_LVL) begin
						state_d = ST_RESP;
					end else begin
						lvl_d = lvl_q + LVL_ONE;
					end
				end else begin
					idx_d = idx_q + node_t'(1);
				end
			end
			// query: fetch both depths, deeper node goes to u
			ST_Q_DV: begin
				du_d = dep_rdata;
				dep_req.rd_en   = 1'b1;
				dep_req.rd_node = v_q;
				state_d = ST_Q_SWAP;
			end
			ST_Q_SWAP: begin
				if (du_q < dep_rdata) begin
					u_d  = v_q;
					v_d  = u_q;
					du_d = dep_rdata;
					dv_d = du_q;
				end else begin
					dv_d = dep_rdata;
				end
				lvl_d   = TOP_LVL;
				state_d = ST_L_CHK;
			end
			// lift u level by level, re-reading its depth after each jump
			ST_L_CHK: begin
				if (lift_jump) begin
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_lvl  = lvl_q;
					tbl_req.rd_node = u_q;
					state_d = ST_L_TBL;
				end else if (lvl_q == '0) begin
					state_d = ST_L_END;
				end else begin
					lvl_d = lvl_q - LVL_ONE;
				end
			end
			ST_L_TBL: begin
				u_d = tbl_rdata;
				dep_req.rd_en   = 1'b1;
				dep_req.rd_node = tbl_rdata;
				state_d = ST_L_DEP;
			end
			ST_L_DEP: begin
				du_d = dep_rdata;
				if (lvl_q == '0) begin
					state_d = ST_L_END;
				end else begin
					lvl_d   = lvl_q - LVL_ONE;
					state_d = ST_L_CHK;
				end
			end
			ST_L_END: begin
				if (u_q == v_q) begin
					ans_d   = u_q;
					state_d = ST_RESP;
				end else begin
					lvl_d = TOP_LVL;
					tbl_req.rd_en   = 1'b1;
					tbl_req.rd_lvl  = TOP_LVL;
					tbl_req.rd_node = u_q;
					state_d = ST_J_RV;
				end
			end
			// joint jump, two table reads per level
			ST_J_RV: begin
				pu_d = tbl_rdata;
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_lvl  = lvl_q;
				tbl_req.rd_node = v_q;
				state_d = ST_J_CMP;
			end
			ST_J_CMP: begin
				u_d = nu;
				v_d = nv;
				tbl_req.rd_en   = 1'b1;
				tbl_req.rd_node = nu;
				if (lvl_q == '0) begin
					tbl_req.rd_lvl = '0;
					state_d = ST_F_CAP;
				end else begin
					tbl_req.rd_lvl = lvl_q - LVL_ONE;
					lvl_d   = lvl_q - LVL_ONE;
					state_d = ST_J_RV;
				end
			end
			ST_F_CAP: begin
				ans_d   = tbl_rdata;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// level counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= '0;
		end else begin
			lvl_q <= lvl_d;
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		u_q    <= u_d;
		v_q    <= v_d;
		du_q   <= du_d;
		dv_q   <= dv_d;
		pu_q   <= pu_d;
		idx_q  <= idx_d;
		ans_q  <= ans_d;
		kind_q <= kind_d;
	end

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= node_t'(1);
		end else if (cfg_valid && cfg_ready) begin
			node_count_q <= cfg_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (state_q == ST_RESP && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && out_free) begin
			m_anc_q  <= ans_q;
			m_kind_q <= kind_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {(M_TDATA_W-NODE_W)'(0), m_anc_q};
	assign m_tuser  = m_kind_q;

	// checks
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, !s_tready)
	`ASSERT_IMPL(a_lvl_range, clk, arst_n, state_q != ST_IDLE, lvl_q <= TOP_LVL)
	`ASSERT_NEXT(a_resp_holds, clk, arst_n, state_q == ST_RESP && !out_free, state_q == ST_RESP)
	`ASSERT_IMPL(a_build_no_lvl0, clk, arst_n, state_q == ST_B_WR, tbl_req.wr_lvl != '0)

endmodule

FILE: rtl/core/blca_store.sv
// Ancestor table and depth store, synchronous (registered) reads.
// Node 0 reads as 0 on both. Depends on blca_pkg.
module blca_store (
	input  logic                clk,
	input  blca_pkg::tbl_req_t  tbl_req,
	input  blca_pkg::dep_req_t  dep_req,
	output blca_pkg::node_t     tbl_rdata,
	output blca_pkg::node_t     dep_rdata
);
	import blca_pkg::*;

	node_t tbl_mem [TBL_DEPTH];
	node_t dep_mem [MAX_NODES];

	logic [TBL_AW-1:0] tbl_raddr;
	logic [TBL_AW-1:0] tbl_waddr;
	node_t             tbl_data_q;
	node_t             dep_data_q;
	logic              tbl_zero_q;
	logic              dep_zero_q;

	// row = level, column = node
	assign tbl_raddr = TBL_AW'({tbl_req.rd_lvl, tbl_req.rd_node});
	assign tbl_waddr = TBL_AW'({tbl_req.wr_lvl, tbl_req.wr_node});

	// ancestor table
	always_ff @(posedge clk) begin
		if (tbl_req.wr_en) begin
			tbl_mem[tbl_waddr] <= tbl_req.wr_data;
		end
		if (tbl_req.rd_en) begin
			tbl_data_q <= tbl_mem[tbl_raddr];
			tbl_zero_q <= (tbl_req.rd_node == '0);
		end
	end

	// depth store
	always_ff @(posedge clk) begin
		if (dep_req.wr_en) begin
			dep_mem[dep_req.wr_node] <= dep_req.wr_data;
		end
		if (dep_req.rd_en) begin
			dep_data_q <= dep_mem[dep_req.rd_node];
			dep_zero_q <= (dep_req.rd_node == '0);
		end
	end

	// absent parent reads as zero
	assign tbl_rdata = tbl_zero_q ? '0 : tbl_data_q;
	assign dep_rdata = dep_zero_q ? '0 : dep_data_q;

endmodule

FILE: sim/tb.sv
// Self-checking bench for binary_lifting_lca_unit: loads random forests, builds the
// ancestor table and checks every result beat against an in-bench prediction.
// Depends on blca_pkg and binary_lifting_lca_unit.
module tb;
	import blca_pkg::*;

	// command code the block acknowledges without acting on it
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// predicted tree state plus the queue of result beats still owed by the block
	class lca_scoreboard;
		typedef struct packed {
			node_t ancestor;
			logic  kind;
		} lca_beat_t;

		node_t     jump_table [0:MAX_NODES*LOG_LEVELS-1];
		node_t     node_depths [0:MAX_NODES-1];
		node_t     node_count;
		lca_beat_t awaited_beats [$];
		int        mismatches;

		function new();
			foreach (jump_table[i]) jump_table[i] = '0;
			foreach (node_depths[i]) node_depths[i] = '0;
			node_count = 1;
			mismatches = 0;
		endfunction

		// 2^lvl-th ancestor; node 0 has none
		function node_t hop(node_t node, int lvl);
			if (node == '0 || lvl >= LOG_LEVELS)
				return '0;
			return jump_table[node*LOG_LEVELS + lvl];
		endfunction

		function int depth_at(node_t node);
			if (node == '0)
				return 0;
			return int'(node_depths[node]);
		endfunction

		// levels 1 and up for nodes 1..node_count
		function void fill_levels();
			for (int j = 1; j < LOG_LEVELS; j++)
				for (int i = 1; i <= int'(node_count); i++)
					jump_table[i*LOG_LEVELS + j] = hop(hop(node_t'(i), j - 1), j - 1);
		endfunction

		function node_t lca_of(node_t u, node_t v);
			node_t t;
			node_t pu;
			node_t pv;
			if (depth_at(u) < depth_at(v)) begin
				t = u;
				u = v;
				v = t;
			end
			// lift the deeper node to the other's depth
			for (int j = LOG_LEVELS - 1; j >= 0; j--)
				if (depth_at(u) - depth_at(v) >= (1 << j))
					u = hop(u, j);
			if (u == v)
				return u;
			// jump both while their ancestors differ
			for (int j = LOG_LEVELS - 1; j >= 0; j--) begin
				pu = hop(u, j);
				pv = hop(v, j);
				if (pu != pv) begin
					u = pu;
					v = pv;
				end
			end
			return hop(u, 0);
		endfunction

		function void note_request(logic [CMD_W-1:0] op, node_t a, node_t b, node_t d);
			lca_beat_t beat;
			beat.ancestor = '0;
			beat.kind = KIND_ACK;
			case (op)
				CMD_LOAD: begin
					if (a != '0) begin
						jump_table[a*LOG_LEVELS] = b;
						node_depths[a] = d;
					end
				end
				CMD_BUILD: fill_levels();
				CMD_QUERY: begin
					beat.ancestor = lca_of(a, b);
					beat.kind = KIND_ANSWER;
				end
				default: ;
			endcase
			awaited_beats.insert(awaited_beats.size(), beat);
		endfunction

		function void check_result(node_t anc, logic kind);
			lca_beat_t want;
			if (awaited_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with none awaited: ancestor %0d kind %0d",
						$time, anc, kind);
				return;
			end
			want = awaited_beats.pop_front();
			if (anc !== want.ancestor || kind !== want.kind) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: ancestor exp %0d got %0d, kind exp %0d got %0d",
						$time, want.ancestor, anc, want.kind, kind);
			end
		endfunction

		function int pending();
			return awaited_beats.size();
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [NODE_W-1:0] cfg_data = '0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [31:0]       s_tdata = '0;   // [9:0] first_node, [19:10] second_node, [29:20] node_depth
	logic [CMD_W-1:0]  s_tuser = '0;   // [1:0] cmd
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;        // [9:0] ancestor
	logic              m_tuser;        // [0] result_kind

	lca_scoreboard board;
	int src_gap_pct = 0;
	int sink_stall_pct = 0;
	int items_sent = 0;
	int hold_left = 0;
	bit hold_request = 0;

	binary_lifting_lca_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	initial begin
		#60_000_000;
		$display("tb NOT OK");
		$finish;
	end

	// result side: check accepted beats, random stalls, long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				board.check_result(m_tdata[NODE_W-1:0], m_tuser);
			if (hold_request) begin
				hold_left = 300;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// one input beat; valid stays up afterwards unless the next call idles
	task automatic send_item(logic [CMD_W-1:0] op, node_t a, node_t b, node_t d);
		while ($urandom_range(99) < src_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, d, b, a};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_request(op, a, b, d);
		items_sent++;
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_node_count(node_t count);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= count;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		board.node_count = count;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_idling(int idx);
		case (idx % 4)
			0: begin
				src_gap_pct = 0;
				sink_stall_pct = 0;
			end
			1: begin
				src_gap_pct = 48;
				sink_stall_pct = 0;
			end
			2: begin
				src_gap_pct = 0;
				sink_stall_pct = 48;
			end
			default: begin
				src_gap_pct = 21;
				sink_stall_pct = 21;
			end
		endcase
	endtask

	// random forest on nodes 1..n, labels shuffled, mostly consistent depths
	task automatic load_tree(int n);
		node_t label [0:MAX_NODES-1];
		int    lvl [0:MAX_NODES-1];
		int    p;
		int    k;
		int    dep;
		node_t tmp;
		label[0] = '0;
		lvl[0] = -1;
		for (int i = 1; i <= n; i++)
			label[i] = node_t'(i);
		for (int i = n; i >= 2; i--) begin
			k = $urandom_range(i, 1);
			tmp = label[i];
			label[i] = label[k];
			label[k] = tmp;
		end
		for (int i = 1; i <= n; i++) begin
			if (i == 1 || $urandom_range(99) < 8)
				p = 0;
			else if ($urandom_range(99) < 50)
				p = i - 1;
			else
				p = $urandom_range(i - 1, 1);
			lvl[i] = lvl[p] + 1;
			dep = lvl[i];
			if ($urandom_range(99) < 3)
				dep = $urandom_range(1023);
			send_item(CMD_LOAD, label[i], label[p], node_t'(dep));
		end
	endtask

	function automatic node_t pick_node(int n);
		if ($urandom_range(99) < 5)
			return '0;
		return node_t'($urandom_range(n, 1));
	endfunction

	// count, tree, build, then a query mix with reloads, rebuilds and noise
	task automatic run_phase(int n, int nq);
		int r;
		write_node_count(node_t'(n));
		load_tree(n);
		send_item(CMD_BUILD, node_t'($urandom), node_t'($urandom), node_t'($urandom));
		for (int q = 0; q < nq; q++) begin
			r = $urandom_range(99);
			if (r < 6)
				send_item(CMD_LOAD, '0, node_t'($urandom), node_t'($urandom));
			else if (r < 9)
				send_item(CMD_UNUSED, node_t'($urandom), node_t'($urandom),
					node_t'($urandom));
			else if (r < 13)
				send_item(CMD_LOAD, node_t'($urandom_range(n, 1)),
					node_t'($urandom_range(n, 0)), node_t'($urandom));
			else if (r < 16)
				send_item(CMD_BUILD, node_t'($urandom), node_t'($urandom),
					node_t'($urandom));
			else
				send_item(CMD_QUERY, pick_node(n), pick_node(n), node_t'($urandom));
		end
	endtask

	initial begin
		int idx;
		int n;
		board = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load of node zero, unused command, all-ones fields
		set_idling(0);
		send_item(CMD_LOAD, '0, 10'd1023, 10'd1023);
		send_item(CMD_UNUSED, 10'd1023, 10'd1023, 10'd1023);
		send_item(CMD_LOAD, 10'd1023, '0, '0);
		send_item(CMD_QUERY, 10'd1023, 10'd1023, 10'd1023);

		// empty build, then a tiny tree
		write_node_count('0);
		send_item(CMD_BUILD, '0, '0, '0);
		write_node_count(10'd3);
		send_item(CMD_LOAD, 10'd1, '0, '0);
		send_item(CMD_LOAD, 10'd2, 10'd1, 10'd1);
		send_item(CMD_LOAD, 10'd3, 10'd1, 10'd1);
		send_item(CMD_BUILD, '0, '0, '0);
		send_item(CMD_QUERY, 10'd2, 10'd3, '0);
		send_item(CMD_QUERY, 10'd3, 10'd2, '0);
		send_item(CMD_QUERY, 10'd2, 10'd1, '0);
		send_item(CMD_QUERY, 10'd1, 10'd1, '0);
		send_item(CMD_QUERY, '0, 10'd2, '0);
		send_item(CMD_QUERY, '0, '0, '0);

		// depth that contradicts the parent link
		send_item(CMD_LOAD, 10'd3, 10'd2, 10'd1023);
		send_item(CMD_QUERY, 10'd3, 10'd2, '0);
		send_item(CMD_QUERY, 10'd1, 10'd3, '0);

		// hold the result side off while queries keep coming
		wait_idle();
		hold_request = 1;
		for (int i = 0; i < 12; i++)
			send_item(CMD_QUERY, node_t'($urandom_range(3, 1)),
				node_t'($urandom_range(3, 0)), '0);

		// random phases, one of them with the full node range
		idx = 0;
		while (items_sent < 1450) begin
			set_idling(idx);
			if (idx == 2) begin
				run_phase(1023, 80);
			end else begin
				n = ($urandom_range(99) < 15) ? $urandom_range(200, 41) : $urandom_range(40, 1);
				run_phase(n, $urandom_range(80, 30));
			end
			idx++;
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (board.mismatches == 0 && board.pending() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end
endmodule
